// File: rtl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // Default coordinate width and the fixed widths of the interface fields.
  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned ByteW            = 8;
  localparam int unsigned SizeW            = 13;
  localparam int unsigned OutCoordW        = 12;
  localparam int unsigned ButtonW          = 3;
  localparam int unsigned CfgIndexW        = 1;
  localparam int unsigned DeltaW           = 10;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] RegScreenWidth  = 1'd0;
  localparam logic [CfgIndexW-1:0] RegScreenHeight = 1'd1;

  // Register reset values.
  localparam logic [SizeW-1:0] ScreenWidthReset  = 13'd1024;
  localparam logic [SizeW-1:0] ScreenHeightReset = 13'd768;
  localparam int unsigned      CursorColReset    = 512;
  localparam int unsigned      CursorRowReset    = 384;

  // Bit positions in the status and header bytes.
  localparam int unsigned StatusReadyBit = 0;
  localparam int unsigned StatusAuxBit   = 5;
  localparam int unsigned HeaderSyncBit  = 3;
  localparam int unsigned HeaderXSignBit = 4;
  localparam int unsigned HeaderYSignBit = 5;

  // Packet phase. The fourth code is never entered and acts as the header phase.
  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhXData  = 2'd1,
    PhYData  = 2'd2
  } phase_e;

endpackage

// File: rtl/ps2mct_axis_clamp.sv
// ----------------------------------------------------------------------------
// ps2mct_axis_clamp
// Adds a signed delta to one cursor coordinate and clamps to 0..size-1.
// ----------------------------------------------------------------------------
module ps2mct_axis_clamp #(
  parameter int unsigned CoordBits = ps2mct_pkg::CoordBitsDefault
) (
  input  logic [CoordBits-1:0]              pos_i,
  input  logic signed [ps2mct_pkg::DeltaW-1:0] delta_i,
  input  logic [ps2mct_pkg::SizeW-1:0]      size_i,
  output logic [CoordBits-1:0]              pos_o
);

  // Wide enough for the size, the largest bound and the sum, with a sign bit.
  localparam int unsigned MagW =
      (CoordBits > ps2mct_pkg::SizeW) ? CoordBits : ps2mct_pkg::SizeW;
  localparam int unsigned SumW = MagW + 3;

  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] bound;
  logic signed [SumW-1:0] max_bound;
  logic signed [SumW-1:0] size_ext;

  always_comb begin
    max_bound = SumW'(1) << CoordBits;
    size_ext  = signed'(SumW'(size_i));
    sum       = signed'(SumW'(pos_i)) + SumW'(delta_i);
    // A zero size behaves as one; a size past the coordinate range saturates.
    priority if (size_ext == '0) begin
      bound = SumW'(1);
    end else if (size_ext > max_bound) begin
      bound = max_bound;
    end else begin
      bound = size_ext;
    end
    priority if (sum < 0) begin
      pos_o = '0;
    end else if (sum >= bound) begin
      pos_o = CoordBits'(bound - SumW'(1));
    end else begin
      pos_o = CoordBits'(sum);
    end
  end

endmodule

// File: rtl/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Assembles three-byte PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Output: a result is registered into the output register, or into the skid
// entry if a stalled word waits there, as its third byte is taken.
// Throughput: one byte per cycle unless stalled. A two-entry output buffer
// lets bytes flow while one word waits; input stalls only when both are full.
// Reset: cursor at 512/384 (masked to the coordinate width), phase at
// header, screen 1024 x 768, output empty.
module ps2_mouse_cursor_tracker #(
  parameter int unsigned CoordBits = ps2mct_pkg::CoordBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ps2mct_pkg::ByteW-1:0]         port_status_i,
  input  logic [ps2mct_pkg::ByteW-1:0]         port_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ps2mct_pkg::OutCoordW-1:0]     cursor_x_o,
  output logic [ps2mct_pkg::OutCoordW-1:0]     cursor_y_o,
  output logic [ps2mct_pkg::ButtonW-1:0]       button_bits_o,
  input  logic                                 cfg_we_i,
  input  logic [ps2mct_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [ps2mct_pkg::SizeW-1:0]         cfg_data_i
);

  typedef struct packed {
    logic [ps2mct_pkg::OutCoordW-1:0] x;
    logic [ps2mct_pkg::OutCoordW-1:0] y;
    logic [ps2mct_pkg::ButtonW-1:0]   buttons;
  } result_t;

  logic [ps2mct_pkg::SizeW-1:0] width_q, height_q;
  ps2mct_pkg::phase_e           phase_q, phase_d;
  logic [ps2mct_pkg::ByteW-1:0] header_q, header_d;
  logic [ps2mct_pkg::ByteW-1:0] xbyte_q, xbyte_d;
  logic [CoordBits-1:0]         col_q, col_d, col_new;
  logic [CoordBits-1:0]         row_q, row_d, row_new;

  logic                         accept;
  logic                         byte_ok;
  logic                         res_valid;
  result_t                      res;
  logic signed [ps2mct_pkg::DeltaW-1:0] dx, neg_dy;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_fire;

  assign accept  = in_valid_i && !in_stall_o;
  assign byte_ok = accept && port_status_i[ps2mct_pkg::StatusReadyBit]
                          && port_status_i[ps2mct_pkg::StatusAuxBit];

  // Nine-bit deltas take their sign from the header only.
  assign dx     = ps2mct_pkg::DeltaW'(signed'({header_q[ps2mct_pkg::HeaderXSignBit],
                                               xbyte_q}));
  assign neg_dy = -ps2mct_pkg::DeltaW'(signed'({header_q[ps2mct_pkg::HeaderYSignBit],
                                                port_data_i}));

  ps2mct_axis_clamp #(.CoordBits(CoordBits)) u_clamp_x (
    .pos_i  (col_q),
    .delta_i(dx),
    .size_i (width_q),
    .pos_o  (col_new)
  );

  ps2mct_axis_clamp #(.CoordBits(CoordBits)) u_clamp_y (
    .pos_i  (row_q),
    .delta_i(neg_dy),
    .size_i (height_q),
    .pos_o  (row_new)
  );

  always_comb begin
    phase_d   = phase_q;
    header_d  = header_q;
    xbyte_d   = xbyte_q;
    col_d     = col_q;
    row_d     = row_q;
    res_valid = 1'b0;
    if (byte_ok) begin
      unique case (phase_q)
        ps2mct_pkg::PhXData: begin
          xbyte_d = port_data_i;
          phase_d = ps2mct_pkg::PhYData;
        end
        ps2mct_pkg::PhYData: begin
          phase_d   = ps2mct_pkg::PhHeader;
          col_d     = col_new;
          row_d     = row_new;
          res_valid = 1'b1;
        end
        default: begin
          // A header without the sync bit is dropped so the stream can realign.
          phase_d = ps2mct_pkg::PhHeader;
          if (port_data_i[ps2mct_pkg::HeaderSyncBit]) begin
            header_d = port_data_i;
            phase_d  = ps2mct_pkg::PhXData;
          end
        end
      endcase
    end
    res.x       = ps2mct_pkg::OutCoordW'(col_new);
    res.y       = ps2mct_pkg::OutCoordW'(row_new);
    res.buttons = header_q[ps2mct_pkg::ButtonW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ps2mct_pkg::ScreenWidthReset;
      height_q <= ps2mct_pkg::ScreenHeightReset;
      phase_q  <= ps2mct_pkg::PhHeader;
      header_q <= '0;
      xbyte_q  <= '0;
      col_q    <= CoordBits'(ps2mct_pkg::CursorColReset);
      row_q    <= CoordBits'(ps2mct_pkg::CursorRowReset);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ps2mct_pkg::RegScreenWidth:  width_q  <= cfg_data_i;
          ps2mct_pkg::RegScreenHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q  <= phase_d;
      header_q <= header_d;
      xbyte_q  <= xbyte_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // Output register with a skid entry behind it.
  assign out_fire   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) begin
          skid_valid_q <= 1'b0;
        end
      end else if (res_valid) begin
        if (out_valid_q && !out_fire) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_x_o    = out_q.x;
  assign cursor_y_o    = out_q.y;
  assign button_bits_o = out_q.buttons;

endmodule

// File: rtl/ps2mct_checker.sv
// ----------------------------------------------------------------------------
// ps2mct_checker
// Port-level checks of the PS/2 mouse cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ps2mct_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [ps2mct_pkg::OutCoordW-1:0]   cursor_x_o,
  input logic [ps2mct_pkg::OutCoordW-1:0]   cursor_y_o,
  input logic [ps2mct_pkg::ButtonW-1:0]     button_bits_o
);

  // A stalled output word stays valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> $stable(cursor_x_o) && $stable(cursor_y_o)
                                     && $stable(button_bits_o))
    else $error("output payload changed while stalled");

  // The input only stalls when a word is already waiting at the output.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // A word appears only after a byte was taken in the previous cycle.
  a_word_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output word appeared without an accepted byte");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cursor_x_o   (cursor_x_o),
  .cursor_y_o   (cursor_y_o),
  .button_bits_o(button_bits_o)
);
